// File: hw/rtl/shwf_pkg.sv
// Package for the sample history window filter: sizes, command codes and the
// structs passed between the control, store and divider modules.
// No dependencies.
package shwf_pkg;

    localparam int DEPTH    = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 6;
    localparam int TERM_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = TERM_W + ADDR_W;
    localparam int DIV_W    = SAMPLE_W + ADDR_W;
    localparam int FRAC_W   = 15;
    localparam int PADDR_W  = 3;

    localparam logic [2:0] CMD_PUSH     = 3'd0;
    localparam logic [2:0] CMD_READ     = 3'd1;
    localparam logic [2:0] CMD_FLUSH    = 3'd2;
    localparam logic [2:0] CMD_MEAN     = 3'd3;
    localparam logic [2:0] CMD_WEIGHTED = 3'd4;
    localparam logic [2:0] CMD_LOAD_WGT = 3'd5;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic [WIN_W-1:0] WINDOW_LEN_RESET = WIN_W'(32);

    typedef struct packed {
        logic                       samp_we;
        logic [ADDR_W-1:0]          samp_waddr;
        logic signed [SAMPLE_W-1:0] samp_wdata;
        logic                       samp_re;
        logic [ADDR_W-1:0]          samp_raddr;
        logic                       wgt_we;
        logic [ADDR_W-1:0]          wgt_waddr;
        logic signed [SAMPLE_W-1:0] wgt_wdata;
        logic                       wgt_re;
        logic [ADDR_W-1:0]          wgt_raddr;
    } mem_req_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

// File: hw/rtl/shwf_regs.sv
// APB configuration register for the window length.
// Depends on shwf_pkg.
module shwf_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [shwf_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [shwf_pkg::WIN_W-1:0]      window_len
);
    import shwf_pkg::*;

    logic [WIN_W-1:0] window_len_reg;
    logic [WIN_W-1:0] window_len_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_WINDOW_LEN);

    always_comb
    begin
        window_len_next = window_len_reg;
        if (wr_en)
        begin
            window_len_next = pwdata[WIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
        end
        else
        begin
            window_len_reg <= window_len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_WINDOW_LEN)
        begin
            prdata = {{(32 - WIN_W){1'b0}}, window_len_reg};
        end
    end

    assign window_len = window_len_reg;

endmodule

// File: hw/rtl/shwf_store.sv
// Sample history memory and weight memory, each with a registered read port.
// Weight entries carry valid bits so that unwritten slots read as zero.
// Depends on shwf_pkg.
module shwf_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  shwf_pkg::mem_req_t                 req,
    output logic signed [shwf_pkg::SAMPLE_W-1:0] samp_rdata,
    output logic signed [shwf_pkg::SAMPLE_W-1:0] wgt_rdata
);
    import shwf_pkg::*;

    logic signed [SAMPLE_W-1:0] samp_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] wgt_mem [DEPTH];
    logic [DEPTH-1:0]           wgt_valid_reg;
    logic [DEPTH-1:0]           wgt_valid_next;
    logic signed [SAMPLE_W-1:0] samp_rdata_reg;
    logic signed [SAMPLE_W-1:0] wgt_rdata_reg;
    logic                       wgt_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.samp_we)
        begin
            samp_mem[req.samp_waddr] <= req.samp_wdata;
        end
        if (req.samp_re)
        begin
            samp_rdata_reg <= samp_mem[req.samp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wgt_we)
        begin
            wgt_mem[req.wgt_waddr] <= req.wgt_wdata;
        end
        if (req.wgt_re)
        begin
            wgt_rdata_reg <= wgt_mem[req.wgt_raddr];
            wgt_hit_reg   <= wgt_valid_reg[req.wgt_raddr];
        end
    end

    always_comb
    begin
        wgt_valid_next = wgt_valid_reg;
        if (req.wgt_we)
        begin
            wgt_valid_next[req.wgt_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgt_valid_reg <= '0;
        end
        else
        begin
            wgt_valid_reg <= wgt_valid_next;
        end
    end

    assign samp_rdata = samp_rdata_reg;
    assign wgt_rdata  = wgt_hit_reg ? wgt_rdata_reg : '0;

endmodule

// File: hw/rtl/shwf_div.sv
// Restoring divider, one quotient bit per cycle, for the filter normalization.
// Depends on shwf_pkg.
module shwf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  shwf_pkg::div_req_t           req,
    output logic                         done,
    output logic [shwf_pkg::DIV_W-1:0]   quotient
);
    import shwf_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  divisor_next;
    logic [CNT_W:0]    partial;
    logic              bit_q;

    always_comb
    begin
        partial      = {rem_reg, quo_reg[DIV_W-1]};
        bit_q        = (partial >= {1'b0, divisor_reg});
        step_next    = step_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            step_next    = STEP_W'(DIV_W);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
            if (bit_q)
            begin
                rem_next = CNT_W'(partial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = partial[CNT_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], bit_q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/sample_history_window_filter_unit.sv
// Top level of the sample history window filter: command sequencer,
// accumulator and output register. Depends on shwf_pkg, shwf_regs,
// shwf_store and shwf_div.
//
//  channel  signals                                   direction
//  input    in_valid/in_ready, cmd, value, offset,    in
//           weight_index
//  output   out_valid/out_ready, sample_out,          out
//           filter_out, fill_count, status
//  config   psel, penable, pwrite, paddr, pwdata,     in / out
//           prdata, pready
//
// Push, flush, load weight and unused codes pass through the execute and finish states;
// a read back adds a read wait state, except when the offset is out of range.
// The filter commands read one sample a cycle from the history memory for the n samples
// of the window in use, then wait on the bit-serial divider before the finish state.
// Reset clears the history, the fill count and all weights; no clearing pass is needed.
// A new word is taken while the previous result waits in the output register.
module sample_history_window_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        cmd,
    input  logic signed [15:0]                value,
    input  logic [5:0]                        offset,
    input  logic [4:0]                        weight_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [15:0]                sample_out,
    output logic signed [15:0]                filter_out,
    output logic [5:0]                        fill_count,
    output logic                              status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shwf_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import shwf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_ACC    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic signed [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [ADDR_W-1:0]          wr_reg, wr_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       term_vld_reg, term_vld_next;
    logic                       out_valid_reg, out_valid_next;

    logic [2:0]                 cmd_reg, cmd_next;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic [5:0]                 offset_reg, offset_next;
    logic [ADDR_W-1:0]          widx_reg, widx_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic signed [TERM_W-1:0]   term_reg, term_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic signed [SAMPLE_W-1:0] res_sample_reg, res_sample_next;
    logic signed [SAMPLE_W-1:0] res_filter_reg, res_filter_next;
    logic                       res_status_reg, res_status_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic signed [SAMPLE_W-1:0] filter_out_reg, filter_out_next;
    logic [CNT_W-1:0]           fill_count_reg, fill_count_next;
    logic                       status_reg, status_next;

    logic [WIN_W-1:0]           window_len;
    mem_req_t                   mem_req;
    div_req_t                   div_req;
    logic signed [SAMPLE_W-1:0] samp_rdata;
    logic signed [SAMPLE_W-1:0] wgt_rdata;
    logic                       div_done;
    logic [DIV_W-1:0]           quotient;

    logic [CNT_W-1:0]           count_push;
    logic [WIN_W-1:0]           win_eff;
    logic [ACC_W-1:0]           acc_mag;
    logic                       accept_in;
    logic                       is_filter;

    shwf_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .window_len (window_len)
    );

    shwf_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mem_req),
        .samp_rdata (samp_rdata),
        .wgt_rdata  (wgt_rdata)
    );

    shwf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    assign accept_in = in_valid && (state_reg == S_IDLE);
    assign is_filter = (cmd_reg == CMD_MEAN) || (cmd_reg == CMD_WEIGHTED);
    assign count_push = (count_reg == CNT_W'(DEPTH)) ? count_reg : count_reg + 1'b1;
    assign win_eff    = (window_len == '0) ? WIN_W'(1) : window_len;
    assign acc_mag    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        wr_next         = wr_reg;
        issue_next      = issue_reg;
        rd_vld_next     = 1'b0;
        term_vld_next   = rd_vld_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        offset_next     = offset_reg;
        widx_next       = widx_reg;
        n_next          = n_reg;
        term_next       = term_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        res_sample_next = res_sample_reg;
        res_filter_next = res_filter_reg;
        res_status_next = res_status_reg;
        sample_out_next = sample_out_reg;
        filter_out_next = filter_out_reg;
        fill_count_next = fill_count_reg;
        status_next     = status_reg;
        mem_req         = '0;
        div_req         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_vld_reg)
        begin
            if (cmd_reg == CMD_MEAN)
            begin
                term_next = TERM_W'(samp_rdata);
            end
            else
            begin
                term_next = samp_rdata * wgt_rdata;
            end
        end
        if (term_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(term_reg);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    cmd_next    = cmd;
                    value_next  = value;
                    offset_next = offset;
                    widx_next   = weight_index;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_sample_next = '0;
                res_filter_next = '0;
                res_status_next = 1'b0;
                state_next      = S_FINISH;
                acc_next        = '0;
                issue_next      = '0;
                case (cmd_reg)
                    CMD_PUSH, CMD_MEAN, CMD_WEIGHTED:
                    begin
                        mem_req.samp_we    = 1'b1;
                        mem_req.samp_waddr = wr_reg;
                        mem_req.samp_wdata = value_reg;
                        wr_next            = wr_reg + 1'b1;
                        count_next         = count_push;
                        if (is_filter)
                        begin
                            if (CNT_W'(win_eff) > count_push)
                            begin
                                n_next = count_push;
                            end
                            else
                            begin
                                n_next = CNT_W'(win_eff);
                            end
                            state_next = S_ACC;
                        end
                    end
                    CMD_READ:
                    begin
                        if ((offset_reg == '0) || (CNT_W'(offset_reg) > count_reg))
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            mem_req.samp_re    = 1'b1;
                            mem_req.samp_raddr = wr_reg - offset_reg[ADDR_W-1:0];
                            state_next         = S_RDWAIT;
                        end
                    end
                    CMD_FLUSH:
                    begin
                        count_next = '0;
                        wr_next    = '0;
                    end
                    CMD_LOAD_WGT:
                    begin
                        mem_req.wgt_we    = 1'b1;
                        mem_req.wgt_waddr = widx_reg;
                        mem_req.wgt_wdata = value_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RDWAIT:
            begin
                res_sample_next = samp_rdata;
                state_next      = S_FINISH;
            end
            S_ACC:
            begin
                if (issue_reg < n_reg)
                begin
                    mem_req.samp_re    = 1'b1;
                    mem_req.samp_raddr = wr_reg - issue_reg[ADDR_W-1:0] - 1'b1;
                    mem_req.wgt_re     = 1'b1;
                    mem_req.wgt_raddr  = issue_reg[ADDR_W-1:0];
                    issue_next         = issue_reg + 1'b1;
                    rd_vld_next        = 1'b1;
                end
                else if (!rd_vld_reg && !term_vld_reg)
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = n_reg;
                    if (cmd_reg == CMD_MEAN)
                    begin
                        div_req.dividend = acc_mag[DIV_W-1:0];
                    end
                    else
                    begin
                        div_req.dividend = acc_mag[FRAC_W +: DIV_W];
                    end
                    neg_next   = acc_reg[ACC_W-1];
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        if (quotient > DIV_W'(unsigned'(SAT_LO)))
                        begin
                            res_filter_next = SAT_LO;
                        end
                        else
                        begin
                            res_filter_next = -$signed(quotient[SAMPLE_W-1:0]);
                        end
                    end
                    else
                    begin
                        if (quotient > DIV_W'(unsigned'(SAT_HI)))
                        begin
                            res_filter_next = SAT_HI;
                        end
                        else
                        begin
                            res_filter_next = $signed(quotient[SAMPLE_W-1:0]);
                        end
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = res_sample_reg;
                    filter_out_next = res_filter_reg;
                    fill_count_next = count_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wr_reg        <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            term_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_reg        <= wr_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            term_vld_reg  <= term_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        offset_reg     <= offset_next;
        widx_reg       <= widx_next;
        n_reg          <= n_next;
        term_reg       <= term_next;
        acc_reg        <= acc_next;
        neg_reg        <= neg_next;
        res_sample_reg <= res_sample_next;
        res_filter_reg <= res_filter_next;
        res_status_reg <= res_status_next;
        sample_out_reg <= sample_out_next;
        filter_out_reg <= filter_out_next;
        fill_count_reg <= fill_count_next;
        status_reg     <= status_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign filter_out = filter_out_reg;
    assign fill_count = fill_count_reg;
    assign status     = status_reg;

endmodule

// File: verif/shwf_checker.sv
// Checker for the sample history window filter: watches the word, result and
// register channels, predicts each result and compares it field by field.
// Depends on shwf_pkg.
module shwf_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [2:0]                     cmd,
    input  logic signed [15:0]             value,
    input  logic [5:0]                     offset,
    input  logic [4:0]                     weight_index,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [15:0]             sample_out,
    input  logic signed [15:0]             filter_out,
    input  logic [5:0]                     fill_count,
    input  logic                           status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [shwf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    input  logic [31:0]                    prdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import shwf_pkg::*;

    localparam logic [PADDR_W-1:0] WINDOW_ADDR = PADDR_W'(4 * REG_WINDOW_LEN);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] filter;
        logic [CNT_W-1:0]           fill;
        logic                       status;
    } history_result_t;

    logic signed [SAMPLE_W-1:0] history [DEPTH];
    logic signed [SAMPLE_W-1:0] weights [DEPTH];
    logic [ADDR_W-1:0]          head;
    logic [CNT_W-1:0]           held;
    logic [WIN_W-1:0]           window;
    history_result_t            due_results [$];
    int                         mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t ns shwf_checker: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint x);
        longint hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        longint lo = -hi - 1;
        if (x > hi)
        begin
            return SAMPLE_W'(hi);
        end
        if (x < lo)
        begin
            return SAMPLE_W'(lo);
        end
        return SAMPLE_W'(x);
    endfunction

    task automatic store_sample(input logic signed [SAMPLE_W-1:0] s);
        history[head] = s;
        head = head + 1'b1;
        if (held < DEPTH)
        begin
            held = held + 1'b1;
        end
    endtask

    task automatic run_history_cmd(
        input  logic [2:0]                 c,
        input  logic signed [SAMPLE_W-1:0] v,
        input  logic [5:0]                 off,
        input  logic [4:0]                 slot,
        output history_result_t            r
    );
        int n;
        longint acc;
        logic signed [SAMPLE_W-1:0] s;
        r = '0;
        n = 0;
        acc = 0;
        case (c)
            CMD_PUSH:
            begin
                store_sample(v);
            end
            CMD_READ:
            begin
                if (off == 0 || off > held)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    r.sample = history[head - ADDR_W'(off)];
                end
            end
            CMD_FLUSH:
            begin
                held = '0;
                head = '0;
            end
            CMD_MEAN, CMD_WEIGHTED:
            begin
                store_sample(v);
                n = (window == 0) ? 1 : int'(window);
                if (n > int'(held))
                begin
                    n = int'(held);
                end
                if (n == 0)
                begin
                    n = 1;
                end
                for (int i = 0; i < n; i++)
                begin
                    s = history[head - ADDR_W'(i + 1)];
                    if (c == CMD_MEAN)
                    begin
                        acc += longint'(s);
                    end
                    else
                    begin
                        acc += longint'(s) * longint'(weights[i]);
                    end
                end
                if (c == CMD_MEAN)
                begin
                    r.filter = clamp_sample(acc / n);
                end
                else
                begin
                    r.filter = clamp_sample(acc / (longint'(n) * 32768));
                end
            end
            CMD_LOAD_WGT:
            begin
                weights[slot] = v;
            end
            default:
            begin
            end
        endcase
        r.fill = held;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        history_result_t want;
        history_result_t next_want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                history[i] = '0;
                weights[i] = '0;
            end
            head = '0;
            held = '0;
            window = WINDOW_LEN_RESET;
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("result word with no command word outstanding");
                end
                else
                begin
                    want = due_results.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  sample_out, want.sample));
                    end
                    if (filter_out !== want.filter)
                    begin
                        report_mismatch($sformatf("filter_out %0d, expected %0d",
                                                  filter_out, want.filter));
                    end
                    if (fill_count !== want.fill)
                    begin
                        report_mismatch($sformatf("fill_count %0d, expected %0d",
                                                  fill_count, want.fill));
                    end
                    if (status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  status, want.status));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                run_history_cmd(cmd, value, offset, weight_index, next_want);
                due_results.push_back(next_want);
            end
            if (psel && penable && pready && paddr == WINDOW_ADDR)
            begin
                if (pwrite)
                begin
                    window = pwdata[WIN_W-1:0];
                end
                else if (prdata[WIN_W-1:0] !== window)
                begin
                    report_mismatch($sformatf("window_len read %0d, expected %0d",
                                              prdata[WIN_W-1:0], window));
                end
            end
            outstanding <= due_results.size();
        end
    end

endmodule

// File: verif/tb_sample_history_window_filter_unit.sv
// Testbench top for the sample history window filter: clock, reset, command
// and register stimulus, and the verdict. Depends on shwf_pkg, shwf_checker
// and the sample_history_window_filter_unit RTL.
module tb_sample_history_window_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import shwf_pkg::*;

    localparam logic [PADDR_W-1:0] WINDOW_ADDR = PADDR_W'(4 * REG_WINDOW_LEN);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            cmd = CMD_PUSH;
    logic signed [15:0]    value = '0;
    logic [5:0]            offset = '0;
    logic [4:0]            weight_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    sample_out;
    logic signed [15:0]    filter_out;
    logic [5:0]            fill_count;
    logic                  status;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    fail_count;
    int                    outstanding;
    bit                    calm = 1'b0;
    int                    fill_guess = 0;
    logic [WIN_W-1:0]      window_plan [6] = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd13, 6'd32};

    sample_history_window_filter_unit i_dut (.*);

    shwf_checker i_checker (.*);

    always #10 clk = ~clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 9);
    endfunction

    always @(posedge clk)
    begin
        out_ready <= !take_break();
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_word(
        input logic [2:0]         c,
        input logic signed [15:0] v,
        input logic [5:0]         o,
        input logic [4:0]         w
    );
        if (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (take_break())
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        offset <= o;
        weight_index <= w;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (c == CMD_PUSH || c == CMD_MEAN || c == CMD_WEIGHTED)
        begin
            fill_guess = (fill_guess < DEPTH) ? fill_guess + 1 : DEPTH;
        end
        else if (c == CMD_FLUSH)
        begin
            fill_guess = 0;
        end
    endtask

    task automatic random_word();
        int pick;
        logic [2:0] c;
        logic [5:0] o;
        pick = $urandom_range(999);
        o = 6'($urandom());
        if (pick < 300)
        begin
            c = CMD_PUSH;
        end
        else if (pick < 500)
        begin
            c = CMD_MEAN;
        end
        else if (pick < 680)
        begin
            c = CMD_WEIGHTED;
        end
        else if (pick < 840)
        begin
            c = CMD_READ;
            if (fill_guess > 0 && $urandom_range(9) < 8)
            begin
                o = 6'($urandom_range(fill_guess, 1));
            end
        end
        else if (pick < 960)
        begin
            c = CMD_LOAD_WGT;
        end
        else if (pick < 975)
        begin
            c = CMD_FLUSH;
        end
        else
        begin
            c = 3'($urandom_range(7, 6));
        end
        send_word(c, pick_sample(), o, 5'($urandom()));
    endtask

    task automatic close_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] a,
                              input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_window(input logic [WIN_W-1:0] w);
        logic [31:0] d;
        d = $urandom();
        d[WIN_W-1:0] = w;
        apb_access(1'b1, WINDOW_ADDR, d);
        apb_access(1'b0, WINDOW_ADDR, '0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, WINDOW_ADDR, '0);
        send_word(CMD_READ, 16'sh0000, 6'd0, 5'd0);
        send_word(CMD_READ, 16'sh0000, 6'd1, 5'd0);
        send_word(CMD_MEAN, 16'sh7FFF, 6'd0, 5'd0);
        send_word(CMD_PUSH, 16'sh8000, 6'd0, 5'd0);
        send_word(CMD_MEAN, 16'sh8000, 6'd0, 5'd0);
        send_word(CMD_READ, 16'sh0000, 6'd1, 5'd0);
        send_word(CMD_READ, 16'sh0000, 6'd3, 5'd0);
        send_word(CMD_READ, 16'sh0000, 6'd4, 5'd0);
        send_word(CMD_READ, 16'sh0000, 6'd63, 5'd31);
        send_word(CMD_LOAD_WGT, 16'sh8000, 6'd0, 5'd0);
        send_word(CMD_LOAD_WGT, 16'sh7FFF, 6'd0, 5'd31);
        send_word(CMD_LOAD_WGT, 16'sh4000, 6'd0, 5'd1);
        send_word(CMD_WEIGHTED, 16'sh7FFF, 6'd0, 5'd0);
        send_word(3'd6, 16'shFFFF, 6'd63, 5'd31);
        send_word(3'd7, 16'sh7FFF, 6'd32, 5'd16);
        send_word(CMD_FLUSH, 16'sh0000, 6'd0, 5'd0);
        send_word(CMD_READ, 16'sh0000, 6'd1, 5'd0);
        send_word(CMD_WEIGHTED, 16'sh8000, 6'd0, 5'd0);
        send_word(CMD_MEAN, 16'shFFFF, 6'd0, 5'd0);
        send_word(CMD_PUSH, 16'sh0000, 6'd0, 5'd0);
        send_word(CMD_MEAN, 16'sh0001, 6'd0, 5'd0);
        close_phase();

        foreach (window_plan[p])
        begin
            calm = (p == 3);
            program_window(p == 4 ? WIN_W'($urandom_range(31, 2)) : window_plan[p]);
            repeat (100) random_word();
            close_phase();
        end
        calm = 1'b0;

        repeat (100) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tb_sample_history_window_filter_unit: PASS");
        end
        else
        begin
            $display("tb_sample_history_window_filter_unit: FAIL");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb_sample_history_window_filter_unit: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/shwf_pkg.sv
hw/rtl/shwf_regs.sv
hw/rtl/shwf_store.sv
hw/rtl/shwf_div.sv
hw/rtl/sample_history_window_filter_unit.sv
verif/shwf_checker.sv
verif/tb_sample_history_window_filter_unit.sv
